// ===== rtl/qrs_pkg.sv =====
// Shared types and constants of the quadratic root solver.
package qrs_pkg;

    localparam int TOL_BITS = 16;
    localparam int DEG_BITS = 2;
    localparam int CNT_BITS = 2;

    localparam logic [TOL_BITS-1:0] TOL_RESET  = 16'd1;
    localparam logic [DEG_BITS-1:0] DEG_LINEAR = 2'd1;
    localparam logic [DEG_BITS-1:0] DEG_SQUARE = 2'd2;

    localparam logic [CNT_BITS-1:0] CNT_NONE = 2'd0;
    localparam logic [CNT_BITS-1:0] CNT_ONE  = 2'd1;
    localparam logic [CNT_BITS-1:0] CNT_TWO  = 2'd2;

    // Class of an equation as it moves down the pipeline
    typedef enum logic [2:0] {
        K_NONE,
        K_LINEAR,
        K_QUAD,
        K_DOUBLE,
        K_TWO
    } t_kind;

    // Class and coefficient signs of one word
    typedef struct packed {
        t_kind kind;
        logic  cn;
        logic  bn;
        logic  an;
    } t_flags;

endpackage

// ===== rtl/qrs_front.sv =====
// Front end: accept a word, split coefficients into sign and magnitude, classify.
module qrs_front #(
    parameter int W = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [qrs_pkg::DEG_BITS-1:0]  i_degree,
    input  logic signed [W-1:0]           i_coef_const,
    input  logic signed [W-1:0]           i_coef_linear,
    input  logic signed [W-1:0]           i_coef_square,
    input  logic [qrs_pkg::TOL_BITS-1:0]  i_tol,
    input  logic                          i_full,
    output logic                          o_push,
    output qrs_pkg::t_flags               o_flags,
    output logic [W-1:0]                  o_am,
    output logic [W-1:0]                  o_bm,
    output logic [W-1:0]                  o_cm
);

    logic           r_valid;
    qrs_pkg::t_flags r_flags;
    logic [W-1:0]   r_am, r_bm, r_cm;

    logic           cn, bn, an, is_quad, is_lin, load;
    logic [W-1:0]   cm, bm, am, tolw;
    qrs_pkg::t_flags n_flags;

    // Split into sign and magnitude
    assign cn   = i_coef_const[W-1];
    assign bn   = i_coef_linear[W-1];
    assign an   = i_coef_square[W-1];
    assign cm   = cn ? $unsigned(-i_coef_const)  : $unsigned(i_coef_const);
    assign bm   = bn ? $unsigned(-i_coef_linear) : $unsigned(i_coef_linear);
    assign am   = an ? $unsigned(-i_coef_square) : $unsigned(i_coef_square);
    assign tolw = W'(i_tol);

    // Classify: true quadratic, linear, or constant
    assign is_quad = (i_degree >= qrs_pkg::DEG_SQUARE) && (am >= tolw) && (am != '0);
    assign is_lin  = (i_degree >= qrs_pkg::DEG_LINEAR) && (bm >= tolw) && (bm != '0);

    always_comb begin
        n_flags.cn = cn;
        n_flags.bn = bn;
        n_flags.an = an;
        if (is_quad) begin
            n_flags.kind = qrs_pkg::K_QUAD;
        end else if (is_lin) begin
            n_flags.kind = qrs_pkg::K_LINEAR;
        end else begin
            n_flags.kind = qrs_pkg::K_NONE;
        end
    end

    // Hold the word until the queue takes it
    assign o_push  = r_valid && !i_full;
    assign o_stall = r_valid && i_full;
    assign load    = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= load || (r_valid && !o_push);
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_flags <= n_flags;
            r_am    <= am;
            r_bm    <= bm;
            r_cm    <= cm;
        end
    end

    assign o_flags = r_flags;
    assign o_am    = r_am;
    assign o_bm    = r_bm;
    assign o_cm    = r_cm;

endmodule

// ===== rtl/qrs_queue.sv =====
// Short queue between the front end and the back end.
module qrs_queue #(
    parameter int WIDTH = 102,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + CW'(1);
                2'b01:   r_cnt <= r_cnt - CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // Store the word
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== rtl/qrs_sqrt.sv =====
// Pipelined integer square root, one result bit per stage, with a sideband.
module qrs_sqrt #(
    parameter int SW  = 49,
    parameter int SBW = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [2*SW-1:0]   i_rad,
    input  logic [SBW-1:0]    i_side,
    output logic              o_valid,
    output logic [SW-1:0]     o_root,
    output logic [SBW-1:0]    o_side
);

    logic              r_vld  [SW];
    logic [SW:0]       r_rem  [SW];
    logic [SW-1:0]     r_root [SW];
    logic [2*SW-1:0]   r_rad  [SW];
    logic [SBW-1:0]    r_side [SW];

    for (genvar g = 0; g < SW; g++) begin : g_stage
        logic            vld_in;
        logic [SW:0]     rem_in;
        logic [SW-1:0]   root_in;
        logic [2*SW-1:0] rad_in;
        logic [SBW-1:0]  side_in;
        logic [SW+2:0]   cur, trial, diff;
        logic            ge;

        if (g == 0) begin : g_head
            assign vld_in  = i_valid;
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = i_rad;
            assign side_in = i_side;
        end else begin : g_body
            assign vld_in  = r_vld[g-1];
            assign rem_in  = r_rem[g-1];
            assign root_in = r_root[g-1];
            assign rad_in  = r_rad[g-1];
            assign side_in = r_side[g-1];
        end

        // Bring down two radicand bits and try the next root bit
        assign cur   = {rem_in, rad_in[2*SW-1 -: 2]};
        assign trial = {1'b0, root_in, 2'b01};
        assign ge    = (cur >= trial);
        assign diff  = cur - trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]  <= ge ? diff[SW:0] : cur[SW:0];
                r_root[g] <= {root_in[SW-2:0], ge};
                r_rad[g]  <= rad_in << 2;
                r_side[g] <= side_in;
            end
        end
    end

    assign o_valid = r_vld[SW-1];
    assign o_root  = r_root[SW-1];
    assign o_side  = r_side[SW-1];

endmodule

// ===== rtl/qrs_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with a sideband.
module qrs_div #(
    parameter int NW  = 50,
    parameter int DW  = 33,
    parameter int SBW = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [NW-1:0]   i_num,
    input  logic [DW-1:0]   i_den,
    input  logic [SBW-1:0]  i_side,
    output logic            o_valid,
    output logic [NW-1:0]   o_quot,
    output logic [SBW-1:0]  o_side
);

    logic            r_vld  [NW];
    logic [DW-1:0]   r_rem  [NW];
    logic [NW-1:0]   r_numq [NW];
    logic [DW-1:0]   r_den  [NW];
    logic [SBW-1:0]  r_side [NW];

    for (genvar g = 0; g < NW; g++) begin : g_stage
        logic           vld_in;
        logic [DW-1:0]  rem_in, den_in;
        logic [NW-1:0]  numq_in;
        logic [SBW-1:0] side_in;
        logic [DW:0]    cur, diff;
        logic           ge;

        if (g == 0) begin : g_head
            assign vld_in  = i_valid;
            assign rem_in  = '0;
            assign numq_in = i_num;
            assign den_in  = i_den;
            assign side_in = i_side;
        end else begin : g_body
            assign vld_in  = r_vld[g-1];
            assign rem_in  = r_rem[g-1];
            assign numq_in = r_numq[g-1];
            assign den_in  = r_den[g-1];
            assign side_in = r_side[g-1];
        end

        // Shift in the next numerator bit, subtract the divisor if it fits
        assign cur  = {rem_in, numq_in[NW-1]};
        assign ge   = (cur >= {1'b0, den_in});
        assign diff = cur - {1'b0, den_in};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]  <= ge ? diff[DW-1:0] : cur[DW-1:0];
                r_numq[g] <= {numq_in[NW-2:0], ge};
                r_den[g]  <= den_in;
                r_side[g] <= side_in;
            end
        end
    end

    assign o_valid = r_vld[NW-1];
    assign o_quot  = r_numq[NW-1];
    assign o_side  = r_side[NW-1];

endmodule

// ===== rtl/qrs_back.sv =====
// Back end: discriminant, square root, division, saturation and ordering of the roots.
module qrs_back #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [qrs_pkg::TOL_BITS-1:0]  i_tol,
    input  logic                          i_empty,
    output logic                          o_pop,
    input  qrs_pkg::t_flags               i_flags,
    input  logic [W-1:0]                  i_am,
    input  logic [W-1:0]                  i_bm,
    input  logic [W-1:0]                  i_cm,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [qrs_pkg::CNT_BITS-1:0]  o_root_count,
    output logic signed [W-1:0]           o_root_first,
    output logic signed [W-1:0]           o_root_second,
    output logic                          o_saturated
);

    localparam int PW  = 2 * W;
    localparam int EW  = 2 * W + 2;
    localparam int RW  = 2 * W + qrs_pkg::TOL_BITS + 2;
    localparam int CW  = ((EW + F) > RW) ? (EW + F) : RW;
    localparam int SW  = W + F + 1;
    localparam int NW  = W + F + 2;
    localparam int DW  = W + 1;
    localparam int VW  = NW + 1;
    localparam int FB  = $bits(qrs_pkg::t_flags);
    localparam int SBW = FB + 3 * W;
    localparam int KB  = $bits(qrs_pkg::t_kind);
    localparam logic [NW-1:0] LIM_NEG = NW'(1) << (W - 1);
    localparam logic [NW-1:0] LIM_POS = LIM_NEG - NW'(1);

    logic en;

    // Advance the whole pipeline unless a finished word is held
    assign en    = !o_valid || !i_stall;
    assign o_pop = en && !i_empty;

    // Stage 1: coefficient products
    logic            r1_vld;
    qrs_pkg::t_flags r1_flags;
    logic [W-1:0]    r1_am, r1_bm, r1_cm;
    logic [PW-1:0]   r1_bb, r1_ac, r1_aa;
    logic [PW-1:0]   bb, ac, aa;

    assign bb = i_bm * i_bm;
    assign ac = i_am * i_cm;
    assign aa = i_am * i_am;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= !i_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_flags <= i_flags;
            r1_am    <= i_am;
            r1_bm    <= i_bm;
            r1_cm    <= i_cm;
            r1_bb    <= bb;
            r1_ac    <= ac;
            r1_aa    <= aa;
        end
    end

    // Stage 2: discriminant c1^2 - 4*c0*c2 and tolerance bound 4*c2^2*tol
    logic            r2_vld;
    qrs_pkg::t_flags r2_flags;
    logic [W-1:0]    r2_am, r2_bm, r2_cm;
    logic [EW-1:0]   r2_emag;
    logic            r2_eneg;
    logic [RW-1:0]   r2_rr;
    logic [EW-1:0]   p, q, emag;
    logic            eneg;
    logic [RW-3:0]   aat;

    assign p   = EW'(r1_bb);
    assign q   = {r1_ac, 2'b00};
    assign aat = r1_aa * i_tol;

    always_comb begin
        eneg = 1'b0;
        if ((r1_cm != '0) && (r1_flags.an == r1_flags.cn)) begin
            if (p >= q) begin
                emag = p - q;
            end else begin
                emag = q - p;
                eneg = 1'b1;
            end
        end else begin
            emag = p + q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (en) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_flags <= r1_flags;
            r2_am    <= r1_am;
            r2_bm    <= r1_bm;
            r2_cm    <= r1_cm;
            r2_emag  <= emag;
            r2_eneg  <= eneg;
            r2_rr    <= {aat, 2'b00};
        end
    end

    // Judge the discriminant against the tolerance, then take its root
    logic [CW-1:0]   ef, rw;
    qrs_pkg::t_flags fl3;
    logic            sq_vld;
    logic [SW-1:0]   sq_root;
    logic [SBW-1:0]  sq_side;

    assign ef = CW'({r2_emag, {F{1'b0}}});
    assign rw = CW'(r2_rr);

    always_comb begin
        fl3 = r2_flags;
        if (r2_flags.kind == qrs_pkg::K_QUAD) begin
            if (r2_eneg ? (ef >= rw) : ((ef == '0) && (rw == '0))) begin
                fl3.kind = qrs_pkg::K_NONE;
            end else if (r2_eneg || (ef < rw)) begin
                fl3.kind = qrs_pkg::K_DOUBLE;
            end else begin
                fl3.kind = qrs_pkg::K_TWO;
            end
        end
    end

    qrs_sqrt #(
        .SW  (SW),
        .SBW (SBW)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r2_vld),
        .i_rad   ({r2_emag, {(2 * F){1'b0}}}),
        .i_side  ({fl3, r2_am, r2_bm, r2_cm}),
        .o_valid (sq_vld),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // Stage 4: numerators, divisor and quotient signs
    qrs_pkg::t_flags        f4;
    logic [W-1:0]           am4, bm4, cm4;
    logic signed [VW-1:0]   bsh, nb, v1, v2;
    logic [NW-1:0]          mag1, mag2, num1, num2;
    logic [DW-1:0]          den;
    logic                   neg1, neg2;

    assign {f4, am4, bm4, cm4} = sq_side;
    assign bsh  = VW'({bm4, {F{1'b0}}});
    assign nb   = f4.bn ? bsh : -bsh;
    assign v1   = nb - VW'(sq_root);
    assign v2   = nb + VW'(sq_root);
    assign mag1 = NW'(v1[VW-1] ? -v1 : v1);
    assign mag2 = NW'(v2[VW-1] ? -v2 : v2);

    always_comb begin
        num1 = '0;
        num2 = '0;
        den  = DW'(1);
        neg1 = 1'b0;
        neg2 = 1'b0;
        case (f4.kind)
            qrs_pkg::K_LINEAR: begin
                num1 = NW'({cm4, {F{1'b0}}});
                den  = DW'(bm4);
                neg1 = (cm4 != '0) && (f4.cn == f4.bn);
            end
            qrs_pkg::K_DOUBLE: begin
                num1 = NW'({bm4, {F{1'b0}}});
                den  = {am4, 1'b0};
                neg1 = (bm4 != '0) && (f4.bn == f4.an);
            end
            qrs_pkg::K_TWO: begin
                num1 = mag1;
                num2 = mag2;
                den  = {am4, 1'b0};
                neg1 = v1[VW-1] != f4.an;
                neg2 = v2[VW-1] != f4.an;
            end
            default: begin
                den = DW'(1);
            end
        endcase
    end

    logic                r4_vld;
    qrs_pkg::t_kind      r4_kind;
    logic [NW-1:0]       r4_num1, r4_num2;
    logic [DW-1:0]       r4_den;
    logic                r4_neg1, r4_neg2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (en) begin
            r4_vld <= sq_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_kind <= f4.kind;
            r4_num1 <= num1;
            r4_num2 <= num2;
            r4_den  <= den;
            r4_neg1 <= neg1;
            r4_neg2 <= neg2;
        end
    end

    // Both roots divide side by side
    logic                d_vld, d2_vld;
    logic [NW-1:0]       q1, q2;
    logic [KB:0]         d1_side;
    logic                d2_side;
    qrs_pkg::t_kind      k5;
    logic                n5_1;

    qrs_div #(
        .NW  (NW),
        .DW  (DW),
        .SBW (KB + 1)
    ) u_div_first (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r4_vld),
        .i_num   (r4_num1),
        .i_den   (r4_den),
        .i_side  ({r4_kind, r4_neg1}),
        .o_valid (d_vld),
        .o_quot  (q1),
        .o_side  (d1_side)
    );

    qrs_div #(
        .NW  (NW),
        .DW  (DW),
        .SBW (1)
    ) u_div_second (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r4_vld),
        .i_num   (r4_num2),
        .i_den   (r4_den),
        .i_side  (r4_neg2),
        .o_valid (d2_vld),
        .o_quot  (q2),
        .o_side  (d2_side)
    );

    assign k5   = qrs_pkg::t_kind'(d1_side[KB:1]);
    assign n5_1 = d1_side[0];

    // Saturate, sign and order the roots
    logic [NW-1:0]          lim1, lim2, m1, m2;
    logic                   sat1, sat2;
    logic signed [W-1:0]    x1, x2;
    logic [qrs_pkg::CNT_BITS-1:0] n_count;
    logic signed [W-1:0]    n_first, n_second;
    logic                   n_sat;

    assign lim1 = n5_1 ? LIM_NEG : LIM_POS;
    assign lim2 = d2_side ? LIM_NEG : LIM_POS;
    assign sat1 = q1 > lim1;
    assign sat2 = q2 > lim2;
    assign m1   = sat1 ? lim1 : q1;
    assign m2   = sat2 ? lim2 : q2;
    assign x1   = n5_1 ? -$signed(m1[W-1:0]) : $signed(m1[W-1:0]);
    assign x2   = d2_side ? -$signed(m2[W-1:0]) : $signed(m2[W-1:0]);

    always_comb begin
        n_count  = qrs_pkg::CNT_NONE;
        n_first  = '0;
        n_second = '0;
        n_sat    = 1'b0;
        case (k5)
            qrs_pkg::K_LINEAR, qrs_pkg::K_DOUBLE: begin
                n_count = qrs_pkg::CNT_ONE;
                n_first = x1;
                n_sat   = sat1;
            end
            qrs_pkg::K_TWO: begin
                n_count  = qrs_pkg::CNT_TWO;
                n_first  = (x1 <= x2) ? x1 : x2;
                n_second = (x1 <= x2) ? x2 : x1;
                n_sat    = sat1 || sat2;
            end
            default: begin
                n_count = qrs_pkg::CNT_NONE;
            end
        endcase
    end

    // Output register
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= d_vld && d2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_root_count  <= n_count;
            o_root_first  <= n_first;
            o_root_second <= n_second;
            o_saturated   <= n_sat;
        end
    end

    assign o_valid = r_out_valid;

endmodule

// ===== rtl/quadratic_root_solver_core.sv =====
// Quadratic root solver: one word per cycle sustained unless the output stalls.
// Depth is set by the square root pipeline (one root bit per stage) and the
// two dividers (one quotient bit per stage). Synchronous active-low reset
// empties all stages and the queue and loads the tolerance with 1.
module quadratic_root_solver_core #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_tol_we,
    input  logic [qrs_pkg::TOL_BITS-1:0]  i_tol_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [qrs_pkg::DEG_BITS-1:0]  i_degree,
    input  logic signed [WORD_BITS-1:0]   i_coef_const,
    input  logic signed [WORD_BITS-1:0]   i_coef_linear,
    input  logic signed [WORD_BITS-1:0]   i_coef_square,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [qrs_pkg::CNT_BITS-1:0]  o_root_count,
    output logic signed [WORD_BITS-1:0]   o_root_first,
    output logic signed [WORD_BITS-1:0]   o_root_second,
    output logic                          o_saturated
);

    localparam int W  = WORD_BITS;
    localparam int QW = $bits(qrs_pkg::t_flags) + 3 * W;

    // Tolerance register
    logic [qrs_pkg::TOL_BITS-1:0] r_tol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= qrs_pkg::TOL_RESET;
        end else if (i_tol_we) begin
            r_tol <= i_tol_data;
        end
    end

    qrs_pkg::t_flags f_flags, b_flags;
    logic [W-1:0]    f_am, f_bm, f_cm, b_am, b_bm, b_cm;
    logic            push, pop, full, empty;
    logic [QW-1:0]   q_wdata, q_rdata;

    qrs_front #(
        .W (W)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_degree      (i_degree),
        .i_coef_const  (i_coef_const),
        .i_coef_linear (i_coef_linear),
        .i_coef_square (i_coef_square),
        .i_tol         (r_tol),
        .i_full        (full),
        .o_push        (push),
        .o_flags       (f_flags),
        .o_am          (f_am),
        .o_bm          (f_bm),
        .o_cm          (f_cm)
    );

    assign q_wdata = {f_flags, f_am, f_bm, f_cm};

    qrs_queue #(
        .WIDTH (QW),
        .DEPTH (4)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_wdata),
        .i_pop   (pop),
        .o_data  (q_rdata),
        .o_full  (full),
        .o_empty (empty)
    );

    assign {b_flags, b_am, b_bm, b_cm} = q_rdata;

    qrs_back #(
        .W (W),
        .F (FRAC_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_tol         (r_tol),
        .i_empty       (empty),
        .o_pop         (pop),
        .i_flags       (b_flags),
        .i_am          (b_am),
        .i_bm          (b_bm),
        .i_cm          (b_cm),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_root_count  (o_root_count),
        .o_root_first  (o_root_first),
        .o_root_second (o_root_second),
        .o_saturated   (o_saturated)
    );

    // No roots means all result fields are zero
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_root_count == qrs_pkg::CNT_NONE) |->
            (o_root_first == '0) && (o_root_second == '0) && !o_saturated)
        else $error("root fields set with no root");

    // A single root leaves the second field clear
    a_one_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_root_count == qrs_pkg::CNT_ONE) |-> (o_root_second == '0))
        else $error("second root set with one root");

    // Two roots come smaller first
    a_two_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_root_count == qrs_pkg::CNT_TWO) |-> (o_root_first <= o_root_second))
        else $error("roots out of order");

endmodule

// ===== tb/quadratic_root_solver_core_checker.sv =====
// Checker for the quadratic root solver: predicts every result and compares it.
`timescale 1ns / 100ps

module quadratic_root_solver_core_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_tol_we,
    input  logic [qrs_pkg::TOL_BITS-1:0] i_tol_data,
    input  logic                         i_word_valid,
    input  logic                         i_word_stall,
    input  logic [qrs_pkg::DEG_BITS-1:0] i_degree,
    input  logic signed [31:0]           i_coef_const,
    input  logic signed [31:0]           i_coef_linear,
    input  logic signed [31:0]           i_coef_square,
    input  logic                         i_root_valid,
    input  logic                         i_root_stall,
    input  logic [qrs_pkg::CNT_BITS-1:0] i_root_count,
    input  logic signed [31:0]           i_root_first,
    input  logic signed [31:0]           i_root_second,
    input  logic                         i_saturated,
    output int                           o_fail_count,
    output int                           o_pending,
    output int                           o_by_count [3],
    output int                           o_sat_count
);

    localparam int FRAC = 16;

    typedef struct {
        logic [qrs_pkg::CNT_BITS-1:0] count;
        logic signed [31:0]           first;
        logic signed [31:0]           second;
        logic                         sat;
    } t_roots;

    t_roots                       roots_due [$];
    logic [qrs_pkg::TOL_BITS-1:0] tol_model;

    // Truncated quotient with sign, clamped to the word range
    function automatic longint clamp_quot(bit neg, logic [127:0] num, logic [127:0] den,
                                          inout bit sat);
        logic [127:0] q;
        logic [127:0] lim;
        q   = num / den;
        lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        if (q > lim) begin
            sat = 1'b1;
            q   = lim;
        end
        return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    // Floor square root of a 128-bit value, one bit at a time
    function automatic logic [127:0] floor_sqrt(logic [127:0] x);
        logic [63:0] r;
        logic [63:0] t;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if ({64'd0, t} * {64'd0, t} <= x) r = t;
        end
        return {64'd0, r};
    endfunction

    function automatic t_roots solve_roots(logic [qrs_pkg::DEG_BITS-1:0] deg_in,
                                           logic signed [31:0] c0,
                                           logic signed [31:0] c1, logic signed [31:0] c2,
                                           logic [qrs_pkg::TOL_BITS-1:0] tol);
        t_roots                       res;
        logic [qrs_pkg::DEG_BITS-1:0] deg;
        bit                           cn, bn, an, sat, eneg, sub, n1, n2;
        logic [31:0]                  cm, bm, am;
        logic [127:0]                 t, p, q4, r, emag, ef, s;
        logic signed [131:0]          minus_b, v1, v2;
        longint                       x1, x2;
        res  = '{default: '0};
        sat  = 1'b0;
        eneg = 1'b0;
        deg  = (deg_in == 2'd3) ? qrs_pkg::DEG_SQUARE : deg_in;
        cn = c0[31]; bn = c1[31]; an = c2[31];
        cm = cn ? -c0 : c0;
        bm = bn ? -c1 : c1;
        am = an ? -c2 : c2;
        t  = {112'd0, tol};
        if (deg < qrs_pkg::DEG_SQUARE || {96'd0, am} < t || am == 0) begin
            if (!(deg < qrs_pkg::DEG_LINEAR || {96'd0, bm} < t || bm == 0)) begin
                res.first = 32'(clamp_quot(cm != 0 && cn == bn, {96'd0, cm} << FRAC,
                                           {96'd0, bm}, sat));
                res.count = qrs_pkg::CNT_ONE;
            end
        end else begin
            p   = {96'd0, bm} * {96'd0, bm};
            q4  = ({96'd0, am} * {96'd0, cm}) << 2;
            r   = ({96'd0, am} * {96'd0, am} * t) << 2;
            sub = cm != 0 && an == cn;
            if (sub && p < q4) begin
                emag = q4 - p;
                eneg = 1'b1;
            end else begin
                emag = sub ? p - q4 : p + q4;
            end
            ef = emag << FRAC;
            if (eneg ? ef >= r : (ef == 0 && r == 0)) begin
                res.count = qrs_pkg::CNT_NONE;
            end else if (eneg || ef < r) begin
                res.first = 32'(clamp_quot(bm != 0 && bn == an, {96'd0, bm} << FRAC,
                                           {95'd0, am, 1'b0}, sat));
                res.count = qrs_pkg::CNT_ONE;
            end else begin
                s       = floor_sqrt(emag << (2 * FRAC));
                minus_b = $signed({4'd0, {96'd0, bm} << FRAC});
                if (!bn) minus_b = -minus_b;
                v1 = minus_b - $signed({4'd0, s});
                v2 = minus_b + $signed({4'd0, s});
                n1 = (v1 < 0) != an;
                n2 = (v2 < 0) != an;
                x1 = clamp_quot(n1, 128'(v1 < 0 ? -v1 : v1), {95'd0, am, 1'b0}, sat);
                x2 = clamp_quot(n2, 128'(v2 < 0 ? -v2 : v2), {95'd0, am, 1'b0}, sat);
                res.first  = 32'(x1 <= x2 ? x1 : x2);
                res.second = 32'(x1 <= x2 ? x2 : x1);
                res.count  = qrs_pkg::CNT_TWO;
            end
        end
        res.sat = sat;
        return res;
    endfunction

    assign o_pending = roots_due.size();

    // Track the tolerance, queue predictions, compare results in order
    always @(posedge i_clk) begin
        t_roots want;
        if (!i_rst_n) begin
            tol_model    <= qrs_pkg::TOL_RESET;
            o_fail_count <= 0;
            o_sat_count  <= 0;
            o_by_count   <= '{0, 0, 0};
            roots_due.delete();
        end else begin
            if (i_tol_we) tol_model <= i_tol_data;
            if (i_word_valid && !i_word_stall)
                roots_due.push_back(solve_roots(i_degree, i_coef_const, i_coef_linear,
                                                i_coef_square, tol_model));
            if (i_root_valid && !i_root_stall) begin
                if (roots_due.size() == 0) begin
                    $error("result word with no equation pending");
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = roots_due.pop_front();
                    if (want.count <= qrs_pkg::CNT_TWO)
                        o_by_count[want.count] <= o_by_count[want.count] + 1;
                    if (want.sat) o_sat_count <= o_sat_count + 1;
                    if (i_root_count !== want.count || i_root_first !== want.first ||
                        i_root_second !== want.second || i_saturated !== want.sat) begin
                        o_fail_count <= o_fail_count + 1;
                        if (i_root_count !== want.count)
                            $error("root_count: expected %0d, got %0d", want.count, i_root_count);
                        if (i_root_first !== want.first)
                            $error("root_first: expected %0d, got %0d", want.first, i_root_first);
                        if (i_root_second !== want.second)
                            $error("root_second: expected %0d, got %0d",
                                   want.second, i_root_second);
                        if (i_saturated !== want.sat)
                            $error("saturated: expected %0d, got %0d", want.sat, i_saturated);
                    end
                end
            end
        end
    end

endmodule

// ===== tb/quadratic_root_solver_core_test.sv =====
// Testbench top of the quadratic root solver: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module quadratic_root_solver_core_test;

    localparam logic signed [31:0] ONE  = 32'sh0001_0000;
    localparam logic signed [31:0] WMAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] WMIN = 32'sh8000_0000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 120;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_tol_we = 1'b0;
    logic [qrs_pkg::TOL_BITS-1:0]  i_tol_data = '0;
    logic                          i_valid = 1'b0;
    logic                          o_stall;
    logic [qrs_pkg::DEG_BITS-1:0]  i_degree = '0;
    logic signed [31:0]            i_coef_const = '0;
    logic signed [31:0]            i_coef_linear = '0;
    logic signed [31:0]            i_coef_square = '0;
    logic                          o_valid;
    logic                          i_stall = 1'b0;
    logic [qrs_pkg::CNT_BITS-1:0]  o_root_count;
    logic signed [31:0]            o_root_first;
    logic signed [31:0]            o_root_second;
    logic                          o_saturated;

    int fail_count, pending, sat_count;
    int by_count [3];
    int idle_pct = 0;
    int stall_pct = 0;
    int hold_seq = 0;
    int hold_taken = 0;
    int hold_left = 0;
    int words_sent = 0;

    always #10 i_clk = ~i_clk;

    quadratic_root_solver_core uut (
        .i_clk, .i_rst_n, .i_tol_we, .i_tol_data, .i_valid, .o_stall, .i_degree,
        .i_coef_const, .i_coef_linear, .i_coef_square, .o_valid, .i_stall,
        .o_root_count, .o_root_first, .o_root_second, .o_saturated
    );

    quadratic_root_solver_core_checker roots_check (
        .i_clk, .i_rst_n, .i_tol_we, .i_tol_data,
        .i_word_valid(i_valid), .i_word_stall(o_stall), .i_degree,
        .i_coef_const, .i_coef_linear, .i_coef_square,
        .i_root_valid(o_valid), .i_root_stall(i_stall), .i_root_count(o_root_count),
        .i_root_first(o_root_first), .i_root_second(o_root_second),
        .i_saturated(o_saturated), .o_fail_count(fail_count), .o_pending(pending),
        .o_by_count(by_count), .o_sat_count(sat_count)
    );

    // Stall the result side at random, or hold it off for a long stretch on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_seq != hold_taken) begin
            hold_taken <= hold_seq;
            hold_left  <= HOLD_CYCLES;
            i_stall    <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Offer one word after random idle cycles and return at its accepting edge
    task automatic send_word(logic [qrs_pkg::DEG_BITS-1:0] deg, logic signed [31:0] c0,
                             logic signed [31:0] c1, logic signed [31:0] c2);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_degree      <= deg;
        i_coef_const  <= c0;
        i_coef_linear <= c1;
        i_coef_square <= c2;
        forever begin
            @(negedge i_clk);
            if (!o_stall) break;
        end
        @(posedge i_clk);
        words_sent++;
    endtask

    // Drop valid and wait until every pending result has come back
    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_tolerance(logic [qrs_pkg::TOL_BITS-1:0] tol);
        drain_results();
        i_tol_we   <= 1'b1;
        i_tol_data <= tol;
        @(posedge i_clk);
        i_tol_we   <= 1'b0;
    endtask

    // Coefficient spread over full words, small magnitudes and extremes
    function automatic logic signed [31:0] rand_coef();
        logic signed [31:0] v;
        case ($urandom_range(3))
            0: v = $urandom;
            1: v = $urandom >> $urandom_range(31, 8);
            2: case ($urandom_range(6))
                   0: v = WMIN;
                   1: v = WMAX;
                   2: v = 0;
                   3: v = 1;
                   4: v = ONE;
                   5: v = $urandom_range(65535);
                   default: v = -ONE;
               endcase
            default: v = $urandom >> $urandom_range(16, 0);
        endcase
        if ($urandom_range(1)) v = -v;
        return v;
    endfunction

    // Mostly quadratics built from chosen roots, the rest raw coefficients
    task automatic send_random();
        longint a, r1, r2;
        if ($urandom_range(99) < 60) begin
            a  = longint'($urandom_range(1 << 20, 1)) * ($urandom_range(1) ? 1 : -1);
            r1 = longint'($urandom_range(1 << 21)) - (1 << 20);
            r2 = $urandom_range(4) == 0 ? r1 : longint'($urandom_range(1 << 21)) - (1 << 20);
            send_word(qrs_pkg::DEG_SQUARE, 32'((a * r1 >>> 16) * r2 >>> 16),
                      32'(-((a * (r1 + r2)) >>> 16)), 32'(a));
        end else begin
            send_word(2'($urandom_range(3)), rand_coef(), rand_coef(), rand_coef());
        end
    endtask

    // Extremes, every degree and every class of result
    task automatic send_directed();
        send_word(2'd0, ONE, ONE, ONE);
        send_word(qrs_pkg::DEG_LINEAR, ONE, 0, ONE);
        send_word(qrs_pkg::DEG_LINEAR, ONE, 2 * ONE, 0);
        send_word(qrs_pkg::DEG_LINEAR, WMAX, 1, 0);
        send_word(qrs_pkg::DEG_LINEAR, WMIN, -1, 0);
        send_word(qrs_pkg::DEG_SQUARE, -ONE, 0, ONE);
        send_word(qrs_pkg::DEG_SQUARE, ONE, 2 * ONE, ONE);
        send_word(qrs_pkg::DEG_SQUARE, ONE, 0, ONE);
        send_word(2'd3, -ONE, 0, ONE);
        send_word(qrs_pkg::DEG_SQUARE, ONE, ONE, 1);
        send_word(qrs_pkg::DEG_SQUARE, ONE, ONE, 0);
        send_word(qrs_pkg::DEG_SQUARE, WMIN, WMIN, WMIN);
        send_word(qrs_pkg::DEG_SQUARE, WMAX, WMAX, WMAX);
        send_word(qrs_pkg::DEG_SQUARE, WMAX, 0, WMIN);
        send_word(qrs_pkg::DEG_SQUARE, 2 * ONE, ONE, -ONE);
        send_word(qrs_pkg::DEG_SQUARE, 0, 0, ONE);
        send_word(2'd3, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555);
    endtask

    task automatic send_batch(int n);
        repeat (n) send_random();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset tolerance, no idling
        send_directed();
        send_batch(250);

        // Zero tolerance: exact zeros and zero discriminants
        write_tolerance(16'd0);
        send_directed();
        idle_pct = 61;
        send_batch(300);

        // Largest tolerance, receiver stalling
        write_tolerance(16'hFFFF);
        idle_pct = 0;
        stall_pct = 61;
        send_batch(300);

        // Both sides idle
        write_tolerance(16'd1000);
        idle_pct = 32;
        stall_pct = 32;
        send_batch(300);

        // Long receiver hold-off while the sender keeps offering
        write_tolerance(16'($urandom_range(65535)));
        idle_pct = 0;
        stall_pct = 0;
        hold_seq = hold_seq + 1;
        send_batch(300);

        // Pause until everything is back, then continue
        drain_results();
        stall_pct = 20;
        send_batch(250);
        write_tolerance(16'd1);
        idle_pct = 10;
        send_batch(250);

        drain_results();
        $display("Sent %0d equations over tolerances 0, 1, 1000, 65535 and a random one.",
                 words_sent);
        $display("Results: %0d without root, %0d single, %0d with two roots, %0d clamped.",
                 by_count[0], by_count[1], by_count[2], sat_count);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #50ms;
        $display("FAIL");
        $finish;
    end

endmodule
